@@ rtl/crs_pkg.sv @@
// ----------------------------------------------------------------------------
// crs_pkg
// Types, request and status codes and the per-axis clip function shared by
// the clip rectangle stack.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int COORD_W = 16;
    localparam int CALC_W  = 18;
    localparam int SCR_W   = 13;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CALC_W-1:0]  calc_t;

    typedef enum logic [2:0] {
        REQ_PUSH_RECT   = 3'd0,
        REQ_PUSH_NOCLIP = 3'd1,
        REQ_POP         = 3'd2,
        REQ_CLIP_BOX    = 3'd3,
        REQ_VISIBLE     = 3'd4
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        coord_t     rect_x;
        coord_t     rect_y;
        coord_t     rect_w;
        coord_t     rect_h;
    } req_t;

    typedef struct packed {
        coord_t     clipped_x;
        coord_t     clipped_y;
        coord_t     clipped_w;
        coord_t     clipped_h;
        logic       was_changed;
        logic       is_visible;
        logic [1:0] stack_status;
    } rsp_t;

    // Stored region entry: {bottom, right, top, left}
    typedef struct packed {
        coord_t bottom;
        coord_t right;
        coord_t top;
        coord_t left;
    } region_t;

    typedef struct packed {
        calc_t p;
        calc_t n;
    } axis_t;

    function automatic calc_t sext(input coord_t v);
        return {{(CALC_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // One axis: position p, length n, against edges lo..hi
    function automatic axis_t clip_axis(input calc_t p_in, input calc_t n_in,
                                        input calc_t lo, input calc_t hi);
        axis_t r;
        r.p = p_in;
        r.n = n_in;
        if (r.p < lo)
        begin
            r.n = r.n - (lo - r.p);
            if (r.n < 0)
            begin
                r.n = '0;
            end
            r.p = lo;
        end
        else if (r.p > hi)
        begin
            r.p = hi;
        end
        if ((r.p + r.n) > hi)
        begin
            r.n = (r.p < hi) ? (hi - r.p) : '0;
        end
        return r;
    endfunction

endpackage

@@ rtl/crs_ram.sv @@
// ----------------------------------------------------------------------------
// crs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module crs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/clip_rectangle_stack.sv @@
// ----------------------------------------------------------------------------
// clip_rectangle_stack
// Bounded stack of clip regions with push, pop, clip-box and visible test.
// ----------------------------------------------------------------------------
//  Port group | Direction | Handshake         | Beat
//  in_*       | in        | in_valid/in_stall | one request (crs_pkg::req_t)
//  out_*      | out       | out_valid/out_stall | one response (crs_pkg::rsp_t)
//  cfg_*      | in        | cfg_wr_en         | one screen size register
//
//  Two steps per request: the idle step reads the top level from the RAM,
//  the compute step clips, updates the stack and loads the response register.
//  After reset the stack sits at the base level (no clip); no clearing pass.
//  A stalled response holds the block in its compute step until taken;
//  a new request is taken while a finished response waits.
// ----------------------------------------------------------------------------
module clip_rectangle_stack #(
    parameter int MAX_LEVEL = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  crs_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output crs_pkg::rsp_t               out_data,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [crs_pkg::SCR_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_LEVEL + 1;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] MAX_PTR = PTR_W'(MAX_LEVEL);
    localparam int REG_W = $bits(crs_pkg::region_t);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t                     state_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [DEPTH-1:0]           has_reg;
    crs_pkg::req_t              req_reg;
    crs_pkg::rsp_t              rsp_reg;
    logic                       out_valid_reg;
    logic [crs_pkg::SCR_W-1:0]  width_reg;
    logic [crs_pkg::SCR_W-1:0]  height_reg;

    crs_pkg::region_t           top_rd;
    logic [REG_W-1:0]           rd_data;
    crs_pkg::region_t           wr_region;
    logic                       wr_en;
    logic [PTR_W-1:0]           ptr_inc;

    logic                       fire;
    logic                       top_has;
    crs_pkg::calc_t             lo_x, hi_x, lo_y, hi_y;
    crs_pkg::calc_t             scr_r, scr_b;
    crs_pkg::calc_t             x, y, w, h, xw, yh;
    crs_pkg::axis_t             ax, ay;
    crs_pkg::calc_t             push_r, push_b;

    crs_pkg::rsp_t              rsp_next;
    logic [PTR_W-1:0]           ptr_next;
    logic [DEPTH-1:0]           has_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;
    assign fire      = (state_reg == ST_CALC) && (!out_valid_reg || !out_stall);
    assign ptr_inc   = ptr_reg + 1'b1;
    assign top_rd    = crs_pkg::region_t'(rd_data);

    crs_ram #(
        .WIDTH (REG_W),
        .DEPTH (DEPTH)
    ) u_region_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_inc),
        .wr_data (wr_region),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        top_has = has_reg[ptr_reg];
        scr_r   = crs_pkg::calc_t'({1'b0, width_reg}) - crs_pkg::calc_t'(1);
        scr_b   = crs_pkg::calc_t'({1'b0, height_reg}) - crs_pkg::calc_t'(1);
        if (top_has)
        begin
            lo_x = crs_pkg::sext(top_rd.left);
            hi_x = crs_pkg::sext(top_rd.right);
            lo_y = crs_pkg::sext(top_rd.top);
            hi_y = crs_pkg::sext(top_rd.bottom);
        end
        else
        begin
            lo_x = '0;
            hi_x = scr_r;
            lo_y = '0;
            hi_y = scr_b;
        end

        x  = crs_pkg::sext(req_reg.rect_x);
        y  = crs_pkg::sext(req_reg.rect_y);
        w  = crs_pkg::sext(req_reg.rect_w);
        h  = crs_pkg::sext(req_reg.rect_h);
        xw = x + w;
        yh = y + h;

        ax = crs_pkg::clip_axis(x, w, lo_x, hi_x);
        ay = crs_pkg::clip_axis(y, h, lo_y, hi_y);
        push_r = ax.p + ax.n;
        push_b = ay.p + ay.n;

        rsp_next  = '0;
        ptr_next  = ptr_reg;
        has_next  = has_reg;
        wr_en     = 1'b0;
        wr_region = '0;

        unique case (req_reg.req_type)
            crs_pkg::REQ_PUSH_RECT,
            crs_pkg::REQ_PUSH_NOCLIP:
            begin
                if (ptr_reg == MAX_PTR)
                begin
                    rsp_next.stack_status = crs_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    if (req_reg.req_type == crs_pkg::REQ_PUSH_RECT)
                    begin
                        has_next[ptr_inc] = 1'b1;
                        wr_en = fire;
                        if ((w > 0) && (h > 0))
                        begin
                            wr_region.left   = ax.p[crs_pkg::COORD_W-1:0];
                            wr_region.top    = ay.p[crs_pkg::COORD_W-1:0];
                            wr_region.right  = push_r[crs_pkg::COORD_W-1:0];
                            wr_region.bottom = push_b[crs_pkg::COORD_W-1:0];
                        end
                        else
                        begin
                            wr_region.right  = scr_r[crs_pkg::COORD_W-1:0];
                            wr_region.bottom = scr_b[crs_pkg::COORD_W-1:0];
                        end
                    end
                    else
                    begin
                        has_next[ptr_inc] = 1'b0;
                    end
                end
            end
            crs_pkg::REQ_POP:
            begin
                if (ptr_reg != '0)
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
                else
                begin
                    rsp_next.stack_status = crs_pkg::STATUS_UNDERFLOW;
                end
            end
            crs_pkg::REQ_CLIP_BOX:
            begin
                rsp_next.clipped_x   = ax.p[crs_pkg::COORD_W-1:0];
                rsp_next.clipped_y   = ay.p[crs_pkg::COORD_W-1:0];
                rsp_next.clipped_w   = ax.n[crs_pkg::COORD_W-1:0];
                rsp_next.clipped_h   = ay.n[crs_pkg::COORD_W-1:0];
                rsp_next.was_changed = (ax.p != x) || (ay.p != y) ||
                                       (ax.n != w) || (ay.n != h);
            end
            crs_pkg::REQ_VISIBLE:
            begin
                rsp_next.is_visible = (xw > 0) && (yh > 0) &&
                    (!top_has || ((x < hi_x) && (xw > lo_x) &&
                                  (y < hi_y) && (yh > lo_y)));
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            has_reg       <= '0;
            req_reg       <= '0;
            rsp_reg       <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= crs_pkg::SCR_W'(640);
            height_reg    <= crs_pkg::SCR_W'(480);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    crs_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    crs_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall && !fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (fire)
                    begin
                        rsp_reg       <= rsp_next;
                        out_valid_reg <= 1'b1;
                        ptr_reg       <= ptr_next;
                        has_reg       <= has_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ bench/clip_rectangle_stack_test.sv @@
// ----------------------------------------------------------------------------
// clip_rectangle_stack_test
// Self-checking bench for the clip rectangle stack. A queue-fed driver sends
// push, pop, clip-box, visible and spare requests. A clocked monitor predicts
// each response from its own copy of the stack and screen size and checks
// the responses in order. The bench runs several screen sizes, the extremes
// among them, under three request/response throttling mixes.
// ----------------------------------------------------------------------------
module clip_rectangle_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_TOP       = 15;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int REPORT_LIMIT    = 10;
    localparam int QUIET_LIMIT     = 4000;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    crs_pkg::req_t                in_data;
    logic                         out_valid;
    logic                         out_stall;
    crs_pkg::rsp_t                out_data;
    logic                         cfg_wr_en;
    logic                         cfg_index;
    logic [crs_pkg::SCR_W-1:0]    cfg_data;

    crs_pkg::req_t pending_requests[$];
    crs_pkg::rsp_t expected_responses[$];
    logic          in_fired;
    int unsigned   send_idle_pct;
    int unsigned   stall_pct;
    int            failures;
    int            quiet_cycles;

    // Predicted stack and screen size
    int unsigned       scr_width;
    int unsigned       scr_height;
    int                level;
    bit                level_clips[STACK_TOP+1];
    crs_pkg::region_t  level_rgn[STACK_TOP+1];

    clip_rectangle_stack #(
        .MAX_LEVEL (STACK_TOP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic clip_span(inout int p, inout int n, input int lo, input int hi);
        if (p < lo)
        begin
            n = n - (lo - p);
            if (n < 0)
            begin
                n = 0;
            end
            p = lo;
        end
        else if (p > hi)
        begin
            p = hi;
        end
        if (p + n > hi)
        begin
            n = (p < hi) ? hi - p : 0;
        end
    endtask

    task automatic clip_against_top(inout int x, inout int y, inout int w, inout int h);
        int l;
        int t;
        int r;
        int b;
        if (level_clips[level])
        begin
            l = level_rgn[level].left;
            t = level_rgn[level].top;
            r = level_rgn[level].right;
            b = level_rgn[level].bottom;
        end
        else
        begin
            l = 0;
            t = 0;
            r = int'(scr_width) - 1;
            b = int'(scr_height) - 1;
        end
        clip_span(x, w, l, r);
        clip_span(y, h, t, b);
    endtask

    task automatic predict_response(input crs_pkg::req_t rq, output crs_pkg::rsp_t rsp);
        int x;
        int y;
        int w;
        int h;
        int cx;
        int cy;
        int cw;
        int ch;
        x   = rq.rect_x;
        y   = rq.rect_y;
        w   = rq.rect_w;
        h   = rq.rect_h;
        rsp = '0;
        case (rq.req_type)
            crs_pkg::REQ_PUSH_RECT, crs_pkg::REQ_PUSH_NOCLIP:
            begin
                if (level >= STACK_TOP)
                begin
                    rsp.stack_status = crs_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    if (rq.req_type == crs_pkg::REQ_PUSH_RECT)
                    begin
                        if (w > 0 && h > 0)
                        begin
                            clip_against_top(x, y, w, h);
                            w = x + w;
                            h = y + h;
                        end
                        else
                        begin
                            x = 0;
                            y = 0;
                            w = int'(scr_width) - 1;
                            h = int'(scr_height) - 1;
                        end
                    end
                    level++;
                    level_clips[level]      = (rq.req_type == crs_pkg::REQ_PUSH_RECT);
                    level_rgn[level].left   = crs_pkg::coord_t'(x);
                    level_rgn[level].top    = crs_pkg::coord_t'(y);
                    level_rgn[level].right  = crs_pkg::coord_t'(w);
                    level_rgn[level].bottom = crs_pkg::coord_t'(h);
                end
            end
            crs_pkg::REQ_POP:
            begin
                if (level > 0)
                begin
                    level--;
                end
                else
                begin
                    rsp.stack_status = crs_pkg::STATUS_UNDERFLOW;
                end
            end
            crs_pkg::REQ_CLIP_BOX:
            begin
                cx = x;
                cy = y;
                cw = w;
                ch = h;
                clip_against_top(cx, cy, cw, ch);
                rsp.clipped_x   = crs_pkg::coord_t'(cx);
                rsp.clipped_y   = crs_pkg::coord_t'(cy);
                rsp.clipped_w   = crs_pkg::coord_t'(cw);
                rsp.clipped_h   = crs_pkg::coord_t'(ch);
                rsp.was_changed = (cx != x || cy != y || cw != w || ch != h);
            end
            crs_pkg::REQ_VISIBLE:
            begin
                if (x + w > 0 && y + h > 0)
                begin
                    if (!level_clips[level])
                    begin
                        rsp.is_visible = 1'b1;
                    end
                    else
                    begin
                        rsp.is_visible = x < int'(level_rgn[level].right)
                                      && x + w > int'(level_rgn[level].left)
                                      && y < int'(level_rgn[level].bottom)
                                      && y + h > int'(level_rgn[level].top);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic crs_pkg::coord_t extreme_coord();
        case ($urandom_range(3))
            0:       return crs_pkg::coord_t'(16'h8000);
            1:       return crs_pkg::coord_t'(16'h7fff);
            2:       return crs_pkg::coord_t'(-1);
            default: return crs_pkg::coord_t'(0);
        endcase
    endfunction

    function automatic crs_pkg::coord_t pick_coord(input int span);
        int unsigned choice;
        choice = $urandom_range(99);
        if (choice < 70)
        begin
            return crs_pkg::coord_t'(int'($urandom_range(span + 128)) - 64);
        end
        else if (choice < 80)
        begin
            return extreme_coord();
        end
        return crs_pkg::coord_t'($urandom);
    endfunction

    function automatic crs_pkg::coord_t pick_extent(input int span);
        int unsigned choice;
        choice = $urandom_range(99);
        if (choice < 55)
        begin
            return crs_pkg::coord_t'($urandom_range(span / 2 + 16, 1));
        end
        else if (choice < 70)
        begin
            return crs_pkg::coord_t'(-int'($urandom_range(8)));
        end
        else if (choice < 80)
        begin
            return extreme_coord();
        end
        return crs_pkg::coord_t'($urandom);
    endfunction

    // grow set: pushes dominate, so the stack climbs toward overflow
    function automatic crs_pkg::req_t random_request(input bit grow);
        crs_pkg::req_t rq;
        int unsigned   pick;
        pick = $urandom_range(99);
        if (pick < (grow ? 40 : 10))
        begin
            rq.req_type = crs_pkg::REQ_PUSH_RECT;
        end
        else if (pick < (grow ? 50 : 15))
        begin
            rq.req_type = crs_pkg::REQ_PUSH_NOCLIP;
        end
        else if (pick < (grow ? 62 : 50))
        begin
            rq.req_type = crs_pkg::REQ_POP;
        end
        else if (pick < 78)
        begin
            rq.req_type = crs_pkg::REQ_CLIP_BOX;
        end
        else if (pick < 95)
        begin
            rq.req_type = crs_pkg::REQ_VISIBLE;
        end
        else
        begin
            rq.req_type = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
        end
        rq.rect_x = pick_coord(scr_width);
        rq.rect_y = pick_coord(scr_height);
        rq.rect_w = pick_extent(scr_width);
        rq.rect_h = pick_extent(scr_height);
        return rq;
    endfunction

    task automatic add_request(input logic [2:0] kind, input int x, input int y,
                               input int w, input int h);
        crs_pkg::req_t rq;
        rq.req_type = kind;
        rq.rect_x   = crs_pkg::coord_t'(x);
        rq.rect_y   = crs_pkg::coord_t'(y);
        rq.rect_w   = crs_pkg::coord_t'(w);
        rq.rect_h   = crs_pkg::coord_t'(h);
        pending_requests.push_back(rq);
    endtask

    task automatic queue_directed();
        add_request(crs_pkg::REQ_POP, 0, 0, 0, 0);
        add_request(crs_pkg::REQ_CLIP_BOX, -32768, -32768, 32767, 32767);
        add_request(crs_pkg::REQ_VISIBLE, -10, 5, 10, 5);
        add_request(crs_pkg::REQ_VISIBLE, 0, 0, 1, 1);
        add_request(crs_pkg::REQ_PUSH_RECT, 100, 50, 200, 100);
        add_request(crs_pkg::REQ_CLIP_BOX, 90, 40, 50, 300);
        add_request(crs_pkg::REQ_VISIBLE, 300, 150, 10, 10);
        add_request(crs_pkg::REQ_VISIBLE, -5, -5, 4, 60);
        add_request(crs_pkg::REQ_PUSH_RECT, 0, 0, 0, 10);
        add_request(crs_pkg::REQ_PUSH_RECT, 5, 5, 10, -3);
        add_request(crs_pkg::REQ_PUSH_NOCLIP, 0, 0, 0, 0);
        add_request(crs_pkg::REQ_VISIBLE, -32768, -32768, 32767, 32767);
        for (logic [3:0] code = REQ_SPARE_FIRST; code <= REQ_SPARE_LAST; code++)
        begin
            add_request(code[2:0], $urandom, $urandom, $urandom, $urandom);
        end
        add_request(crs_pkg::REQ_PUSH_RECT, -32768, -32768, 32767, 32767);
        // fill the stack, last push overflows
        for (int k = 6; k <= STACK_TOP + 1; k++)
        begin
            add_request(crs_pkg::REQ_PUSH_RECT, k * 20, k * 10, 300, 200);
        end
    endtask

    task automatic write_screen(input int unsigned width, input int unsigned height);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= crs_pkg::CFG_SCREEN_WIDTH;
        cfg_data  <= crs_pkg::SCR_W'(width);
        @(negedge clk);
        cfg_index <= crs_pkg::CFG_SCREEN_HEIGHT;
        cfg_data  <= crs_pkg::SCR_W'(height);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        scr_width  = width & 32'h1fff;
        scr_height = height & 32'h1fff;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : request_driver
        if (rst_n)
        begin
            if (!in_valid || in_fired)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
        else
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : response_monitor
        crs_pkg::rsp_t fresh;
        crs_pkg::rsp_t want;
        in_fired <= in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%t: response beat with none expected: %h", $realtime, out_data);
                end
            end
            else
            begin
                want = expected_responses.pop_front();
                if (out_data.clipped_x !== want.clipped_x
                    || out_data.clipped_y !== want.clipped_y
                    || out_data.clipped_w !== want.clipped_w
                    || out_data.clipped_h !== want.clipped_h
                    || out_data.was_changed !== want.was_changed
                    || out_data.is_visible !== want.is_visible
                    || out_data.stack_status !== want.stack_status)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("%t: mismatch exp x=%0d y=%0d w=%0d h=%0d chg=%b vis=%b st=%0d",
                                 $realtime, want.clipped_x, want.clipped_y, want.clipped_w,
                                 want.clipped_h, want.was_changed, want.is_visible,
                                 want.stack_status);
                        $display("%t:          got x=%0d y=%0d w=%0d h=%0d chg=%b vis=%b st=%0d",
                                 $realtime, out_data.clipped_x, out_data.clipped_y,
                                 out_data.clipped_w, out_data.clipped_h, out_data.was_changed,
                                 out_data.is_visible, out_data.stack_status);
                    end
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predict_response(in_data, fresh);
            expected_responses.push_back(fresh);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%t: no beat for %0d cycles", $realtime, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : sequencer
        int unsigned widths[PHASES]  = '{640, 1, 4096, 0, 8191, 100};
        int unsigned heights[PHASES] = '{480, 1, 4096, 8191, 0, 37};
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = crs_pkg::CFG_SCREEN_WIDTH;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        failures      = 0;
        quiet_cycles  = 0;
        scr_width     = 640;
        scr_height    = 480;
        level         = 0;
        foreach (level_clips[i])
        begin
            level_clips[i] = 1'b0;
            level_rgn[i]   = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 30;
                stall_pct     = 59;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 59;
                stall_pct     = 30;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            write_screen(widths[ph], heights[ph]);
            if (ph == 0)
            begin
                queue_directed();
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pending_requests.push_back(random_request(((i / 40) % 2) == 0));
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (failures == 0 && expected_responses.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/crs_pkg.sv
rtl/crs_ram.sv
rtl/clip_rectangle_stack.sv
bench/clip_rectangle_stack_test.sv
